/* hdl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the SSIM window mean block
// Geometry limits, field widths, register codes, item structs and the
// request/response structs of the shared restoring divider.
// ----------------------------------------------------------------------------
package swm_pkg;

   // Geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_WINDOW = 16;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int LS_AW  = SLOT_W + COL_W;

   // Register field widths
   localparam int FRAME_W   = 11;
   localparam int WIN_W     = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH  = 2'd3;

   // Sum widths
   localparam int LIN_W = 12;   // column sum of pixels
   localparam int SQC_W = 21;   // column sum of products
   localparam int SUM_W = 16;   // window sum of pixels
   localparam int SQ_W  = 24;   // window sum of products

   // SSIM coefficients, scaled by 10000 and N^2
   localparam int COEF_CROSS  = 20000;
   localparam int COEF_SQUARE = 10000;
   localparam int C1_SCALED   = 65025;
   localparam int C2_SCALED   = 585225;

   // Mean clamp band, Q2.16
   localparam int MEAN_ONE     = 65536;
   localparam int MEAN_ONE_TOP = 66191;

   // Divider geometry
   localparam int QUOT_W = 18;
   localparam int STEP_W = $clog2(QUOT_W);
   localparam int DEN_W  = 96;
   localparam int NUM_W  = 112;
   localparam int REM_W  = NUM_W + 1;

   typedef struct packed {
      logic [7:0] ref_pixel;
      logic [7:0] test_pixel;
   } req_type;

   typedef struct packed {
      logic signed [17:0] ssim_mean;
      logic [20:0]        windows_counted;
      logic               no_windows;
   } rsp_type;

   typedef struct packed {
      logic [SQC_W-1:0] sxy;
      logic [SQC_W-1:0] syy;
      logic [SQC_W-1:0] sxx;
      logic [LIN_W-1:0] sy;
      logic [LIN_W-1:0] sx;
   } col_sums_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

/* hdl/swm_divider.sv */
// ----------------------------------------------------------------------------
// swm_divider: restoring divider, one quotient bit per cycle
// Divides an unsigned numerator by a nonzero denominator whose quotient is
// known to fit QUOT_W bits. Result is valid in the cycle done is high.
// ----------------------------------------------------------------------------
module swm_divider import swm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  dsh_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              fits_step;
   logic [REM_W-1:0]  rem_diff;

   // Trial subtract of the shifted divisor
   always_comb begin
      fits_step = rem_ff >= dsh_ff;
      rem_diff  = rem_ff - dsh_ff;
   end

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(QUOT_W - 1);
         end else if (busy_ff) begin
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   // Shift remainder and quotient
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= REM_W'(div_req.num);
         dsh_ff  <= REM_W'(div_req.den) << (QUOT_W - 1);
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (fits_step) begin
            rem_ff <= rem_diff;
         end
         quot_ff <= {quot_ff[QUOT_W-2:0], fits_step};
         dsh_ff  <= dsh_ff >> 1;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

/* hdl/ssim_window_mean.sv */
// ----------------------------------------------------------------------------
// ssim_window_mean: streaming SSIM over a sliding window, mean per frame
// Pixel pairs stream in raster order; one result item follows the last pixel.
// ----------------------------------------------------------------------------
// Each pixel pair is a read-modify-write of the per-column sums memory and the
// line store; a pixel that closes no window needs nothing more. A pixel that
// closes a window then runs the SSIM datapath (4 product and scaling steps,
// 3 partial-product steps of the wide multiply and a restoring divide). After
// the last pixel of a frame the mean is formed by the same divider, if any
// window was counted, before the next pixel is taken. Configuration is
// sampled at the first pixel of each frame. Column sums need no clearing pass:
// the first row of a frame ignores the stored value.
// ----------------------------------------------------------------------------
module ssim_window_mean import swm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FRAME_W-1:0]   csr_wdata
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RD     = 4'd1;
   localparam logic [3:0] ST_PROD   = 4'd2;
   localparam logic [3:0] ST_DIFF   = 4'd3;
   localparam logic [3:0] ST_SCALE  = 4'd4;
   localparam logic [3:0] ST_ABS    = 4'd5;
   localparam logic [3:0] ST_MUL    = 4'd6;
   localparam logic [3:0] ST_WSTART = 4'd7;
   localparam logic [3:0] ST_WDIV   = 4'd8;
   localparam logic [3:0] ST_MSTART = 4'd9;
   localparam logic [3:0] ST_MDIV   = 4'd10;
   localparam logic [3:0] ST_FIN    = 4'd11;

   localparam int MUL_STEPS = 3;

   function automatic logic [FRAME_W-1:0] clamp_frame(input logic [FRAME_W-1:0] v,
                                                       input logic [FRAME_W-1:0] lim);
      logic [FRAME_W-1:0] r;
      r = v;
      if (v == '0) r = FRAME_W'(1);
      else if (v > lim) r = lim;
      return r;
   endfunction

   function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
      logic [WIN_W-1:0] r;
      r = v;
      if (v == '0) r = WIN_W'(1);
      else if (v > WIN_W'(MAX_WINDOW)) r = WIN_W'(MAX_WINDOW);
      return r;
   endfunction

   // Control state
   logic [3:0]         state_ff;
   logic [FRAME_W-1:0] cfg_fh_ff, cfg_fw_ff;
   logic [WIN_W-1:0]   cfg_wh_ff, cfg_ww_ff;
   logic [FRAME_W-1:0] eff_h_ff, eff_w_ff;
   logic [WIN_W-1:0]   eff_wh_ff, eff_ww_ff;
   logic [8:0]         n_ff;
   logic               fits_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               last_ff;
   logic signed [39:0] acc_ff;
   logic [20:0]        count_ff;
   logic [1:0]         mul_cnt_ff;
   logic               rsp_valid_ff;

   // Payload registers
   logic [7:0]         pix_x_ff, pix_y_ff;
   logic [15:0]        ls_rd_ff;
   col_sums_type       col_cur_ff, col_back_ff;
   logic [SUM_W-1:0]   win_sx_ff, win_sy_ff;
   logic [SQ_W-1:0]    win_sxx_ff, win_syy_ff, win_sxy_ff;
   logic [31:0]        p_xy_ff, p_xx_ff, p_yy_ff;
   logic [32:0]        n_xy_ff, n_xx_ff, n_yy_ff;
   logic [16:0]        nn_ff;
   logic signed [33:0] cov_ff;
   logic [32:0]        sq_ff;
   logic [33:0]        var_ff;
   logic [47:0]        a_ff, d_ff, e_ff;
   logic signed [49:0] b_ff;
   logic               bneg_ff;
   logic [47:0]        bsh_ff, esh_ff;
   logic [95:0]        num_ff, den_ff;
   logic [17:0]        mean_ff;
   rsp_type            rsp_data_ff;

   // Memories
   logic [15:0]        line_mem [MAX_WINDOW * MAX_WIDTH];
   col_sums_type       col_mem [MAX_WIDTH];

   // Combinational signals
   logic               req_accept;
   logic               first_px;
   logic [FRAME_W-1:0] new_h, new_w;
   logic [WIN_W-1:0]   new_wh, new_ww;
   logic [SLOT_W-1:0]  old_slot;
   logic [7:0]         ox, oy;
   logic [15:0]        nxx_p, nyy_p, nxy_p, oxx_p, oyy_p, oxy_p;
   logic               drop_old;
   col_sums_type       col_base, col_new, col_drop;
   logic               counted, last_col, last_row;
   logic [SUM_W-1:0]   win_sx_in, win_sy_in;
   logic [SQ_W-1:0]    win_sxx_in, win_syy_in, win_sxy_in;
   logic [33:0]        n_sum, p_sum;
   logic signed [49:0] b_in;
   logic [63:0]        num_pp, den_pp;
   logic [39:0]        acc_mag;
   logic signed [18:0] win_val, mean_val;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = state_ff != ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Frame geometry taken at the first pixel
   always_comb begin
      first_px = (row_ff == '0) && (col_ff == '0);
      new_h    = clamp_frame(cfg_fh_ff, FRAME_W'(MAX_HEIGHT));
      new_w    = clamp_frame(cfg_fw_ff, FRAME_W'(MAX_WIDTH));
      new_wh   = clamp_win(cfg_wh_ff);
      new_ww   = clamp_win(cfg_ww_ff);
      old_slot = slot_ff - SLOT_W'(eff_wh_ff);
   end

   // Column update and sliding window sums
   always_comb begin
      ox       = ls_rd_ff[15:8];
      oy       = ls_rd_ff[7:0];
      nxx_p    = pix_x_ff * pix_x_ff;
      nyy_p    = pix_y_ff * pix_y_ff;
      nxy_p    = pix_x_ff * pix_y_ff;
      oxx_p    = ox * ox;
      oyy_p    = oy * oy;
      oxy_p    = ox * oy;
      drop_old = row_ff >= ROW_W'(eff_wh_ff);
      col_base = (row_ff == '0) ? '0 : col_cur_ff;
      col_new.sx  = col_base.sx - (drop_old ? LIN_W'(ox) : '0) + LIN_W'(pix_x_ff);
      col_new.sy  = col_base.sy - (drop_old ? LIN_W'(oy) : '0) + LIN_W'(pix_y_ff);
      col_new.sxx = col_base.sxx - (drop_old ? SQC_W'(oxx_p) : '0) + SQC_W'(nxx_p);
      col_new.syy = col_base.syy - (drop_old ? SQC_W'(oyy_p) : '0) + SQC_W'(nyy_p);
      col_new.sxy = col_base.sxy - (drop_old ? SQC_W'(oxy_p) : '0) + SQC_W'(nxy_p);
      col_drop = (col_ff >= COL_W'(eff_ww_ff)) ? col_back_ff : '0;
      if (col_ff == '0) begin
         win_sx_in  = SUM_W'(col_new.sx);
         win_sy_in  = SUM_W'(col_new.sy);
         win_sxx_in = SQ_W'(col_new.sxx);
         win_syy_in = SQ_W'(col_new.syy);
         win_sxy_in = SQ_W'(col_new.sxy);
      end else begin
         win_sx_in  = win_sx_ff + SUM_W'(col_new.sx) - SUM_W'(col_drop.sx);
         win_sy_in  = win_sy_ff + SUM_W'(col_new.sy) - SUM_W'(col_drop.sy);
         win_sxx_in = win_sxx_ff + SQ_W'(col_new.sxx) - SQ_W'(col_drop.sxx);
         win_syy_in = win_syy_ff + SQ_W'(col_new.syy) - SQ_W'(col_drop.syy);
         win_sxy_in = win_sxy_ff + SQ_W'(col_new.sxy) - SQ_W'(col_drop.sxy);
      end
      last_col = (FRAME_W'(col_ff) + 1'b1) >= eff_w_ff;
      last_row = (FRAME_W'(row_ff) + 1'b1) >= eff_h_ff;
      counted  = fits_ff && ((FRAME_W'(row_ff) + 1'b1) >= FRAME_W'(eff_wh_ff))
                 && ((FRAME_W'(col_ff) + 1'b1) >= FRAME_W'(eff_ww_ff));
   end

   // Datapath helpers
   always_comb begin
      n_sum    = 34'(n_xx_ff) + 34'(n_yy_ff);
      p_sum    = 34'(p_xx_ff) + 34'(p_yy_ff);
      b_in     = 50'(cov_ff) * $signed(50'(COEF_CROSS))
                 + $signed(50'(nn_ff) * 50'(C2_SCALED));
      num_pp   = a_ff * bsh_ff[47:32];
      den_pp   = d_ff * esh_ff[47:32];
      acc_mag  = acc_ff[39] ? 40'(-acc_ff) : 40'(acc_ff);
      win_val  = bneg_ff ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
      mean_val = acc_ff[39] ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
      if (mean_val >= 19'(MEAN_ONE) && mean_val <= 19'(MEAN_ONE_TOP)) begin
         mean_val = 19'(MEAN_ONE);
      end
   end

   // Drive the shared divider
   always_comb begin
      div_req.start = (state_ff == ST_WSTART) || ((state_ff == ST_MSTART) && (count_ff != '0));
      if (state_ff == ST_WSTART) begin
         div_req.num = {num_ff, 16'b0};
         div_req.den = den_ff;
      end else begin
         div_req.num = NUM_W'(acc_mag);
         div_req.den = DEN_W'(count_ff);
      end
   end

   swm_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_fh_ff <= FRAME_W'(144);
         cfg_fw_ff <= FRAME_W'(176);
         cfg_wh_ff <= WIN_W'(8);
         cfg_ww_ff <= WIN_W'(8);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_HEIGHT:  cfg_fh_ff <= csr_wdata;
            CSR_FRAME_WIDTH:   cfg_fw_ff <= csr_wdata;
            CSR_WINDOW_HEIGHT: cfg_wh_ff <= csr_wdata[WIN_W-1:0];
            CSR_WINDOW_WIDTH:  cfg_ww_ff <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Line store: read the row leaving the window, write the new pixel
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ls_rd_ff <= line_mem[{old_slot, col_ff}];
      end
      if (state_ff == ST_RD) begin
         line_mem[{slot_ff, col_ff}] <= {pix_x_ff, pix_y_ff};
      end
   end

   // Column sums: read this column and the one leaving the window
   always_ff @(posedge clock) begin
      if (req_accept) begin
         col_cur_ff  <= col_mem[col_ff];
         col_back_ff <= col_mem[col_ff - COL_W'(eff_ww_ff)];
      end
      if (state_ff == ST_RD) begin
         col_mem[col_ff] <= col_new;
      end
   end

   // Sequencer and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eff_h_ff     <= FRAME_W'(144);
         eff_w_ff     <= FRAME_W'(176);
         eff_wh_ff    <= WIN_W'(8);
         eff_ww_ff    <= WIN_W'(8);
         n_ff         <= 9'd64;
         fits_ff      <= 1'b1;
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= '0;
         last_ff      <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         mul_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise the result item at the end of a frame, drop it once taken
         if ((state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (first_px) begin
                     eff_h_ff  <= new_h;
                     eff_w_ff  <= new_w;
                     eff_wh_ff <= new_wh;
                     eff_ww_ff <= new_ww;
                     n_ff      <= 9'(new_wh) * 9'(new_ww);
                     fits_ff   <= (FRAME_W'(new_wh) <= new_h) && (FRAME_W'(new_ww) <= new_w);
                     slot_ff   <= '0;
                     acc_ff    <= '0;
                     count_ff  <= '0;
                  end
                  state_ff <= ST_RD;
               end
            end
            ST_RD: begin
               // Advance the raster position
               last_ff <= last_col && last_row;
               if (last_col) begin
                  col_ff  <= '0;
                  slot_ff <= slot_ff + 1'b1;
                  row_ff  <= last_row ? '0 : row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
               if (counted) state_ff <= ST_PROD;
               else if (last_col && last_row) state_ff <= ST_MSTART;
               else state_ff <= ST_IDLE;
            end
            ST_PROD:  state_ff <= ST_DIFF;
            ST_DIFF:  state_ff <= ST_SCALE;
            ST_SCALE: state_ff <= ST_ABS;
            ST_ABS: begin
               mul_cnt_ff <= '0;
               state_ff   <= ST_MUL;
            end
            ST_MUL: begin
               mul_cnt_ff <= mul_cnt_ff + 1'b1;
               if (mul_cnt_ff == 2'(MUL_STEPS - 1)) state_ff <= ST_WSTART;
            end
            ST_WSTART: state_ff <= ST_WDIV;
            ST_WDIV: begin
               if (div_rsp.done) begin
                  acc_ff   <= acc_ff + 40'(win_val);
                  count_ff <= count_ff + 1'b1;
                  state_ff <= last_ff ? ST_MSTART : ST_IDLE;
               end
            end
            ST_MSTART: begin
               state_ff <= (count_ff == '0) ? ST_FIN : ST_MDIV;
            end
            ST_MDIV: begin
               if (div_rsp.done) state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // SSIM datapath and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_x_ff <= req_data.ref_pixel;
         pix_y_ff <= req_data.test_pixel;
      end
      case (state_ff)
         ST_RD: begin
            win_sx_ff  <= win_sx_in;
            win_sy_ff  <= win_sy_in;
            win_sxx_ff <= win_sxx_in;
            win_syy_ff <= win_syy_in;
            win_sxy_ff <= win_sxy_in;
         end
         ST_PROD: begin
            p_xy_ff <= win_sx_ff * win_sy_ff;
            p_xx_ff <= win_sx_ff * win_sx_ff;
            p_yy_ff <= win_sy_ff * win_sy_ff;
            n_xy_ff <= n_ff * win_sxy_ff;
            n_xx_ff <= n_ff * win_sxx_ff;
            n_yy_ff <= n_ff * win_syy_ff;
            nn_ff   <= n_ff * n_ff;
         end
         ST_DIFF: begin
            cov_ff <= $signed({1'b0, n_xy_ff}) - $signed({2'b0, p_xy_ff});
            sq_ff  <= 33'(p_xx_ff) + 33'(p_yy_ff);
            var_ff <= (n_sum >= p_sum) ? n_sum - p_sum : '0;
         end
         ST_SCALE: begin
            a_ff <= 48'(p_xy_ff) * 48'(COEF_CROSS) + 48'(nn_ff) * 48'(C1_SCALED);
            b_ff <= b_in;
            d_ff <= 48'(sq_ff) * 48'(COEF_SQUARE) + 48'(nn_ff) * 48'(C1_SCALED);
            e_ff <= 48'(var_ff) * 48'(COEF_SQUARE) + 48'(nn_ff) * 48'(C2_SCALED);
         end
         ST_ABS: begin
            bneg_ff <= b_ff[49];
            bsh_ff  <= b_ff[49] ? 48'(-b_ff) : 48'(b_ff);
            esh_ff  <= e_ff;
            num_ff  <= '0;
            den_ff  <= '0;
         end
         ST_MUL: begin
            // Accumulate one 16-bit partial product per cycle, high chunk first
            num_ff <= {num_ff[79:0], 16'b0} + 96'(num_pp);
            den_ff <= {den_ff[79:0], 16'b0} + 96'(den_pp);
            bsh_ff <= {bsh_ff[31:0], 16'b0};
            esh_ff <= {esh_ff[31:0], 16'b0};
         end
         ST_MSTART: begin
            if (count_ff == '0) mean_ff <= '0;
         end
         ST_MDIV: begin
            if (div_rsp.done) mean_ff <= 18'(mean_val);
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_ff.ssim_mean       <= $signed(mean_ff);
               rsp_data_ff.windows_counted <= count_ff;
               rsp_data_ff.no_windows      <= !fits_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

/* hdl/swm_checker.sv */
// ----------------------------------------------------------------------------
// swm_checker: port-level assertions for the SSIM window mean block
// Watches the item channels only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module swm_checker import swm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_type              req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [FRAME_W-1:0]   csr_wdata
);

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // A frame without windows reports zeros
   a_no_win: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_windows |->
         rsp_data.windows_counted == '0 && rsp_data.ssim_mean == '0)
      else $error("no_windows result carries data");

   // Mean stays within [-1, 1]
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.ssim_mean <= 18'sd65536 && rsp_data.ssim_mean >= -18'sd65536)
      else $error("mean out of range");

   // Come out of reset idle with no result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // Stall right after an accepted item while it is processed
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted back to back");

endmodule

bind ssim_window_mean swm_checker u_swm_checker (.*);
